FILE: rtl/core/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int QIDX_W     = 2;

    // Command codes.
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_CALL    = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [2:0] STAT_SERVED    = 3'd0;
    localparam logic [2:0] STAT_NONE      = 3'd1;
    localparam logic [2:0] STAT_ENQUEUED  = 3'd2;
    localparam logic [2:0] STAT_REMOVED   = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;
    localparam logic [2:0] STAT_CLEARED   = 3'd6;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  oper;
        logic [31:0] amount;
    } tcpq_entry_t;

    // Per-row command, shared by every cell of one queue.
    typedef struct packed {
        logic cmp;     // latch id match flags
        logic load;    // write the tail slot
        logic pop;     // shift whole row toward the head
        logic remove;  // shift from the first match onward
    } tcpq_ctrl_t;

endpackage

FILE: rtl/core/tcpq_cell.sv
`timescale 1ns / 1ps

module tcpq_cell
    import tcpq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  logic        aclk,
    input  tcpq_ctrl_t  ctrl,
    input  logic [15:0] cmp_id,
    input  logic [LEN_W-1:0] len,
    input  tcpq_entry_t load_entry,
    input  tcpq_entry_t nbr_entry,
    input  logic        chain_in,
    output tcpq_entry_t entry,
    output logic        chain_out
);

    tcpq_entry_t entry_reg;
    logic        match_reg;
    logic        occupied;

    assign occupied  = (len > LEN_W'(IDX));
    assign entry     = entry_reg;
    // Once a match is seen, every cell from there to the tail takes its neighbor.
    assign chain_out = chain_in | match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp) begin
            match_reg <= occupied && (entry_reg.id == cmp_id);
        end
        if (ctrl.load && (len == LEN_W'(IDX))) begin
            entry_reg <= load_entry;
        end else if (ctrl.pop || (ctrl.remove && chain_out)) begin
            entry_reg <= nbr_entry;
        end
    end

endmodule

FILE: rtl/core/tcpq_row.sv
`timescale 1ns / 1ps

module tcpq_row
    import tcpq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int LEN_W = 5
) (
    input  logic        aclk,
    input  tcpq_ctrl_t  ctrl,
    input  logic [15:0] cmp_id,
    input  logic [LEN_W-1:0] len,
    input  tcpq_entry_t load_entry,
    output tcpq_entry_t head,
    output logic        found
);

    tcpq_entry_t cell_entry [DEPTH];
    tcpq_entry_t cell_nbr   [DEPTH];
    logic [DEPTH:0] chain;

    assign chain[0] = 1'b0;
    assign head     = cell_entry[0];
    assign found    = chain[DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_last
            assign cell_nbr[i] = '0;
        end else begin : g_mid
            assign cell_nbr[i] = cell_entry[i+1];
        end

        tcpq_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cmp_id     (cmp_id),
            .len        (len),
            .load_entry (load_entry),
            .nbr_entry  (cell_nbr[i]),
            .chain_in   (chain[i]),
            .entry      (cell_entry[i]),
            .chain_out  (chain[i+1])
        );
    end

endmodule

FILE: rtl/core/two_class_priority_queues.sv
`timescale 1ns / 1ps
// Four FIFO queues held in rows of cells, one cell per slot; the head sits in cell 0.
// A request is accepted in ST_IDLE and carried out in ST_EXEC, whose firing writes the
// result registers. The id compare runs on acceptance and the shift or load of the row
// happens when ST_EXEC fires; a stalled result holds ST_EXEC and blocks new requests.
// Reset (synchronous, aresetn low) empties all queues and drops any pending result;
// slot contents are not cleared, so there is no clearing pass.

module two_class_priority_queues
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic        s_resource,
    input  logic        s_priority_class,
    input  logic [15:0] s_cust_id,
    input  logic [2:0]  s_customer_operation,
    input  logic [31:0] s_amount_cents,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_out_id,
    output logic [2:0]  m_out_operation,
    output logic [31:0] m_out_amount_cents,
    output logic        m_from_priority,
    output logic [4:0]  m_queue_length
);

    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    logic [1:0]         op_reg;
    logic               res_reg;
    logic [QIDX_W-1:0]  q_reg;
    tcpq_entry_t        req_entry_reg;
    logic [LEN_W-1:0]   len_reg [NUM_QUEUES];

    logic               m_valid_reg;
    logic [2:0]         status_reg;
    tcpq_entry_t        out_entry_reg;
    logic               from_prio_reg;
    logic [4:0]         out_len_reg;

    logic               accept;
    logic               fire;
    logic [QIDX_W-1:0]  s_q;
    logic [QIDX_W-1:0]  pq;
    logic [QIDX_W-1:0]  gq;
    logic               call_hit;
    logic               call_prio;
    logic [QIDX_W-1:0]  src_q;
    tcpq_ctrl_t         row_ctrl  [NUM_QUEUES];
    tcpq_entry_t        row_head  [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] row_found;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fire    = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign s_q     = {s_resource, s_priority_class};

    // Strict priority: the resource's priority queue first, then its general queue.
    assign pq        = {res_reg, 1'b1};
    assign gq        = {res_reg, 1'b0};
    assign call_prio = (len_reg[pq] != '0);
    assign call_hit  = call_prio || (len_reg[gq] != '0);
    assign src_q     = call_prio ? pq : gq;

    for (genvar r = 0; r < NUM_QUEUES; r++) begin : g_row
        always_comb begin
            row_ctrl[r].cmp    = accept && (s_q == QIDX_W'(r));
            row_ctrl[r].load   = fire && (op_reg == OP_ENQUEUE) && (q_reg == QIDX_W'(r))
                                 && (len_reg[r] < LEN_W'(QUEUE_DEPTH));
            row_ctrl[r].pop    = fire && (op_reg == OP_CALL) && call_hit
                                 && (src_q == QIDX_W'(r));
            row_ctrl[r].remove = fire && (op_reg == OP_REMOVE) && (q_reg == QIDX_W'(r));
        end

        tcpq_row #(
            .DEPTH (QUEUE_DEPTH),
            .LEN_W (LEN_W)
        ) u_row (
            .aclk       (aclk),
            .ctrl       (row_ctrl[r]),
            .cmp_id     (s_cust_id),
            .len        (len_reg[r]),
            .load_entry (req_entry_reg),
            .head       (row_head[r]),
            .found      (row_found[r])
        );
    end

    function automatic logic [4:0] len5(input logic [LEN_W-1:0] n);
        logic [LEN_W+4:0] wide;
        wide = {5'b0, n};
        return wide[4:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                len_reg[k] <= '0;
            end
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg               <= s_op;
                        res_reg              <= s_resource;
                        q_reg                <= s_q;
                        req_entry_reg.id     <= s_cust_id;
                        req_entry_reg.oper   <= s_customer_operation;
                        req_entry_reg.amount <= s_amount_cents;
                        state_reg            <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        // Entry data and the priority flag are carried by a serve only.
                        out_entry_reg <= ((op_reg == OP_CALL) && call_hit) ? row_head[src_q]
                                                                           : '0;
                        from_prio_reg <= (op_reg == OP_CALL) && call_hit && call_prio;
                        state_reg     <= ST_IDLE;
                        case (op_reg)
                            OP_ENQUEUE: begin
                                if (len_reg[q_reg] >= LEN_W'(QUEUE_DEPTH)) begin
                                    status_reg  <= STAT_FULL;
                                    out_len_reg <= len5(len_reg[q_reg]);
                                end else begin
                                    status_reg     <= STAT_ENQUEUED;
                                    len_reg[q_reg] <= len_reg[q_reg] + 1'b1;
                                    out_len_reg    <= len5(len_reg[q_reg] + 1'b1);
                                end
                            end
                            OP_CALL: begin
                                if (call_hit) begin
                                    status_reg     <= STAT_SERVED;
                                    len_reg[src_q] <= len_reg[src_q] - 1'b1;
                                    out_len_reg    <= len5(len_reg[src_q] - 1'b1);
                                end else begin
                                    status_reg  <= STAT_NONE;
                                    out_len_reg <= '0;
                                end
                            end
                            OP_REMOVE: begin
                                if (row_found[q_reg]) begin
                                    status_reg     <= STAT_REMOVED;
                                    len_reg[q_reg] <= len_reg[q_reg] - 1'b1;
                                    out_len_reg    <= len5(len_reg[q_reg] - 1'b1);
                                end else begin
                                    status_reg  <= STAT_NOT_FOUND;
                                    out_len_reg <= len5(len_reg[q_reg]);
                                end
                            end
                            default: begin
                                status_reg     <= STAT_CLEARED;
                                len_reg[q_reg] <= '0;
                                out_len_reg    <= '0;
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_out_id           = out_entry_reg.id;
    assign m_out_operation    = out_entry_reg.oper;
    assign m_out_amount_cents = out_entry_reg.amount;
    assign m_from_priority    = from_prio_reg;
    assign m_queue_length     = out_len_reg;

    // An accepted request blocks the input until its result has been produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in flight");

    // A fresh enqueue result always reports a non-empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid) && (m_status == STAT_ENQUEUED)) |-> (m_queue_length != '0))
        else $error("enqueue reported an empty queue");

    // Only a serve carries entry data or the priority flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_SERVED))
        |-> (!m_from_priority && (m_out_id == '0) && (m_out_operation == '0)
             && (m_out_amount_cents == '0)))
        else $error("entry fields set on a result that is not a serve");

    // An empty call reports a zero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_NONE)) |-> (m_queue_length == '0))
        else $error("empty call reported a nonzero length");

endmodule
